/* sv/arqswt_pkg.sv */
// shared types, constants and helpers of the arq sequence window tracker
`default_nettype none
package arqswt_pkg;

  localparam int SEQ_SPACE = 255;
  localparam int SEQ_W     = $clog2(SEQ_SPACE);
  localparam int CNT_W     = $clog2(SEQ_SPACE + 1);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOT_OUT = 2'd2
  } status_t;

  // classified command handed from front to back
  typedef enum logic [1:0] {
    OP_ALLOC    = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_ERR_FULL = 2'd2,
    OP_ERR_REL  = 2'd3
  } op_t;

  typedef struct packed {
    op_t  op;
    seq_t seq;
  } cmd_entry_t;

  // window state the back exports to the front for classification
  typedef struct packed {
    seq_t oldest;
    cnt_t count;
  } win_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RD,
    BK_CHK
  } bk_state_t;

  function automatic seq_t wrap_inc(seq_t n);
    return (n == seq_t'(SEQ_SPACE - 1)) ? '0 : n + seq_t'(1);
  endfunction

endpackage
`default_nettype wire

/* sv/arqswt_fifo.sv */
// short command queue between front and back
`default_nettype none
module arqswt_fifo (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      push,
  input  arqswt_pkg::cmd_entry_t   push_data,
  input  wire                      pop,
  output arqswt_pkg::cmd_entry_t   pop_data,
  output logic                     empty
);

  arqswt_pkg::cmd_entry_t mem_r [arqswt_pkg::FIFO_DEPTH];
  logic [arqswt_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [arqswt_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [arqswt_pkg::FIFO_AW:0]   cnt_r, cnt_nxt;

  function automatic logic [arqswt_pkg::FIFO_AW-1:0] ptr_inc(
    logic [arqswt_pkg::FIFO_AW-1:0] p);
    return (p == arqswt_pkg::FIFO_AW'(arqswt_pkg::FIFO_DEPTH - 1)) ?
           '0 : p + arqswt_pkg::FIFO_AW'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + (arqswt_pkg::FIFO_AW+1)'(push) - (arqswt_pkg::FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];
  assign empty    = (cnt_r == '0);

endmodule
`default_nettype wire

/* sv/arqswt_front.sv */
// command acceptance and classification against the current window
`default_nettype none
module arqswt_front (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  wire                      in_cmd,
  input  wire  [7:0]               in_seq_no,
  input  arqswt_pkg::win_state_t   win_st,
  input  arqswt_pkg::cnt_t         eff_win,
  input  wire                      done,
  output logic                     push,
  output arqswt_pkg::cmd_entry_t   push_data
);

  logic busy_r, busy_nxt;
  arqswt_pkg::seq_t seq;
  arqswt_pkg::seq_t seq_off;

  always_comb begin
    push = start && !busy_r;
    seq  = in_seq_no[arqswt_pkg::SEQ_W-1:0];
    // distance from the oldest number, modulo the sequence space
    seq_off = (seq >= win_st.oldest) ? seq - win_st.oldest :
              seq - win_st.oldest + arqswt_pkg::seq_t'(arqswt_pkg::SEQ_SPACE);

    push_data.seq = seq;
    if (!in_cmd) begin
      push_data.op = (win_st.count >= eff_win) ? arqswt_pkg::OP_ERR_FULL :
                                                 arqswt_pkg::OP_ALLOC;
    end else if (in_seq_no >= 8'(arqswt_pkg::SEQ_SPACE)) begin
      push_data.op = arqswt_pkg::OP_ERR_REL;
    end else if (arqswt_pkg::CNT_W'(seq_off) >= win_st.count) begin
      push_data.op = arqswt_pkg::OP_ERR_REL;
    end else begin
      push_data.op = arqswt_pkg::OP_RELEASE;
    end

    busy_nxt = busy_r;
    if (push) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

/* sv/arqswt_back.sv */
// window state, done flags, retirement sequencer and result register
`default_nettype none
module arqswt_back (
  input  wire                      clk,
  input  wire                      rst_n,
  input  arqswt_pkg::cmd_entry_t   q_data,
  input  wire                      q_empty,
  output logic                     q_pop,
  input  arqswt_pkg::cnt_t         eff_win,
  output arqswt_pkg::win_state_t   win_st,
  output logic                     done,
  output logic                     out_valid,
  output logic [7:0]               out_alloc_seq_no,
  output logic [1:0]               out_status,
  output logic [7:0]               out_outstanding,
  output logic                     out_available
);

  arqswt_pkg::bk_state_t state_r, state_nxt;
  arqswt_pkg::seq_t next_r, next_nxt;
  arqswt_pkg::seq_t oldest_r, oldest_nxt;
  arqswt_pkg::cnt_t count_r, count_nxt;

  logic                             done_mem [arqswt_pkg::SEQ_SPACE];
  logic [arqswt_pkg::SEQ_SPACE-1:0] done_vld_r;
  logic                             rd_r;

  logic             we;
  arqswt_pkg::seq_t waddr;
  logic             wdata;

  arqswt_pkg::seq_t    res_alloc;
  arqswt_pkg::status_t res_status;
  arqswt_pkg::cnt_t    res_count;

  logic                out_valid_r;
  arqswt_pkg::seq_t    alloc_r;
  arqswt_pkg::status_t status_r;
  arqswt_pkg::cnt_t    outst_r;
  logic                avail_r;

  always_comb begin
    state_nxt  = state_r;
    next_nxt   = next_r;
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    q_pop      = 1'b0;
    done       = 1'b0;
    we         = 1'b0;
    waddr      = next_r;
    wdata      = 1'b0;
    res_alloc  = '0;
    res_status = arqswt_pkg::ST_OK;
    res_count  = count_r;

    case (state_r)
      arqswt_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          case (q_data.op)
            arqswt_pkg::OP_ALLOC: begin
              we        = 1'b1;
              waddr     = next_r;
              wdata     = 1'b0;
              next_nxt  = arqswt_pkg::wrap_inc(next_r);
              count_nxt = count_r + arqswt_pkg::cnt_t'(1);
              res_alloc = next_r;
              res_count = count_nxt;
              done      = 1'b1;
            end
            arqswt_pkg::OP_RELEASE: begin
              we        = 1'b1;
              waddr     = q_data.seq;
              wdata     = 1'b1;
              state_nxt = arqswt_pkg::BK_RD;
            end
            arqswt_pkg::OP_ERR_FULL: begin
              res_status = arqswt_pkg::ST_FULL;
              done       = 1'b1;
            end
            default: begin
              res_status = arqswt_pkg::ST_NOT_OUT;
              done       = 1'b1;
            end
          endcase
        end
      end
      arqswt_pkg::BK_RD: begin
        // flag of the oldest number lands in rd_r at the end of this cycle
        state_nxt = arqswt_pkg::BK_CHK;
      end
      arqswt_pkg::BK_CHK: begin
        if (count_r != '0 && rd_r) begin
          we         = 1'b1;
          waddr      = oldest_r;
          wdata      = 1'b0;
          oldest_nxt = arqswt_pkg::wrap_inc(oldest_r);
          count_nxt  = count_r - arqswt_pkg::cnt_t'(1);
          state_nxt  = arqswt_pkg::BK_RD;
        end else begin
          done      = 1'b1;
          state_nxt = arqswt_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = arqswt_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arqswt_pkg::BK_IDLE;
      next_r      <= '0;
      oldest_r    <= '0;
      count_r     <= '0;
      done_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_r      <= next_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      out_valid_r <= done;
      if (we) begin
        done_vld_r[waddr] <= 1'b1;
      end
    end
  end

  // done flag store, an entry never written reads as cleared
  always_ff @(posedge clk) begin
    if (we) begin
      done_mem[waddr] <= wdata;
    end
    rd_r <= done_mem[oldest_r] & done_vld_r[oldest_r];
  end

  always_ff @(posedge clk) begin
    if (done) begin
      alloc_r  <= res_alloc;
      status_r <= res_status;
      outst_r  <= res_count;
      avail_r  <= (res_count < eff_win);
    end
  end

  assign win_st           = '{oldest: oldest_r, count: count_r};
  assign out_valid        = out_valid_r;
  assign out_alloc_seq_no = 8'(alloc_r);
  assign out_status       = status_r;
  assign out_outstanding  = 8'(outst_r);
  assign out_available    = avail_r;

endmodule
`default_nettype wire

/* sv/arq_sequence_window_tracker.sv */
// arq sequence window tracker: top level with window register and checks
// an item is taken when start is high and busy low; busy stays high until its result
// allocate and error results go through the queue to the registered out_valid strobe,
// and busy drops together with it, so a new command waits for the last one's result
// a release then retires the done entries from the oldest on, the work of the
// retirement sequencer reading one done flag at a time from its store
// synchronous reset clears counters, done flags and the queue; window reset value is 8
`default_nettype none
module arq_sequence_window_tracker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  wire        in_cmd,
  input  wire  [7:0] in_seq_no,
  output logic       out_valid,
  output logic [7:0] out_alloc_seq_no,
  output logic [1:0] out_status,
  output logic [7:0] out_outstanding,
  output logic       out_available,
  input  wire        cfg_we,
  input  wire  [7:0] cfg_wdata
);

  logic [7:0]             win_r;
  arqswt_pkg::cnt_t       eff_win;
  arqswt_pkg::win_state_t win_st;
  arqswt_pkg::cmd_entry_t push_data;
  arqswt_pkg::cmd_entry_t q_data;
  logic                   push;
  logic                   q_pop;
  logic                   q_empty;
  logic                   done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= 8'd8;
    end else if (cfg_we) begin
      win_r <= cfg_wdata;
    end
  end

  // window never exceeds the sequence space
  assign eff_win = (win_r > 8'(arqswt_pkg::SEQ_SPACE)) ?
                   arqswt_pkg::cnt_t'(arqswt_pkg::SEQ_SPACE) :
                   arqswt_pkg::cnt_t'(win_r);

  arqswt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_cmd    (in_cmd),
    .in_seq_no (in_seq_no),
    .win_st    (win_st),
    .eff_win   (eff_win),
    .done      (done),
    .push      (push),
    .push_data (push_data)
  );

  arqswt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  arqswt_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_data           (q_data),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .eff_win          (eff_win),
    .win_st           (win_st),
    .done             (done),
    .out_valid        (out_valid),
    .out_alloc_seq_no (out_alloc_seq_no),
    .out_status       (out_status),
    .out_outstanding  (out_outstanding),
    .out_available    (out_available)
  );

  // a result only follows a transfer still in flight
  a_result_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a pending transfer");

  // an accepted transfer keeps busy high in the next cycle
  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // failed commands hand out no number
  a_err_no_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != arqswt_pkg::ST_OK) |-> (out_alloc_seq_no == 8'd0))
    else $error("number handed out on a failed command");

  // queue never holds work while the front is idle
  a_queue_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy) |-> q_empty)
    else $error("queued command without a pending transfer");

endmodule
`default_nettype wire
